[rtl/mtpc_pkg.sv]
// mtpc_pkg: port codes, routing mode codes and register indexes for the turn check
package mtpc_pkg;

	typedef logic [2:0] port_code_t;
	typedef logic [2:0] mode_code_t;
	typedef logic [2:0] reg_index_t;

	localparam port_code_t PORT_N = 3'd0;
	localparam port_code_t PORT_E = 3'd1;
	localparam port_code_t PORT_S = 3'd2;
	localparam port_code_t PORT_W = 3'd3;
	localparam port_code_t PORT_U = 3'd4;
	localparam port_code_t PORT_D = 3'd5;

	localparam int NUM_PORTS = 6;

	typedef logic [NUM_PORTS-1:0] port_set_t;

	localparam mode_code_t MODE_ANY      = 3'd0;
	localparam mode_code_t MODE_NEG_1ST  = 3'd1;
	localparam mode_code_t MODE_OE       = 3'd2;
	localparam mode_code_t MODE_DOWN_OE  = 3'd3;
	localparam mode_code_t MODE_OE_NMIN  = 3'd4;
	localparam mode_code_t MODE_BALANCED = 3'd5;

	localparam reg_index_t REG_MODE   = 3'd0;
	localparam reg_index_t REG_SIZE_X = 3'd1;
	localparam reg_index_t REG_SIZE_Y = 3'd2;
	localparam reg_index_t REG_SIZE_Z = 3'd3;
	localparam reg_index_t REG_NODE_X = 3'd4;
	localparam reg_index_t REG_NODE_Y = 3'd5;
	localparam reg_index_t REG_NODE_Z = 3'd6;

	localparam int SIZE_BITS = 5;

endpackage

[rtl/mtpc_decide.sv]
// mtpc_decide: combinational admissible-port sets and turn decision per routing mode
module mtpc_decide import mtpc_pkg::*; #(
	parameter int COORD_BITS = 4
) (
	input  mode_code_t              routing_mode,
	input  logic [SIZE_BITS-1:0]    mesh_size_y,
	input  logic [SIZE_BITS-1:0]    mesh_size_z,
	input  logic [COORD_BITS-1:0]   node_x,
	input  logic [COORD_BITS-1:0]   node_y,
	input  logic [COORD_BITS-1:0]   node_z,
	input  port_code_t              port_in,
	input  port_code_t              port_out,
	input  logic [COORD_BITS-1:0]   dest_x,
	input  logic [COORD_BITS-1:0]   dest_y,
	input  logic [COORD_BITS-1:0]   dest_z,
	output logic                    turn_allowed
);

	localparam int EW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1;

	logic x_lt, x_eq, x_gt, y_lt, y_eq, y_gt, z_lt, z_eq, z_gt;
	logic x_next, z_next;
	logic cx_odd, dx_odd, cz_odd;
	logic same_x, same_z;
	logic y_room, z_room;
	logic at_dest_xy;
	port_set_t m_oe, m_nm, m_ns, m_xyz, m_nf, m_sel;
	logic [7:0] m_ext;
	logic bal_ok;

	always_comb begin
		x_lt = dest_x < node_x;
		x_eq = dest_x == node_x;
		x_gt = dest_x > node_x;
		y_lt = dest_y < node_y;
		y_eq = dest_y == node_y;
		y_gt = dest_y > node_y;
		z_lt = dest_z < node_z;
		z_eq = dest_z == node_z;
		z_gt = dest_z > node_z;
		x_next = {1'b0, dest_x} == ({1'b0, node_x} + (COORD_BITS+1)'(1));
		z_next = {1'b0, dest_z} == ({1'b0, node_z} + (COORD_BITS+1)'(1));
		cx_odd = node_x[0];
		dx_odd = dest_x[0];
		cz_odd = node_z[0];
		// previous node offset is never zero for an east/west or up/down arrival
		same_x = (port_in != PORT_E) && (port_in != PORT_W);
		same_z = (port_in != PORT_U) && (port_in != PORT_D);
		y_room = (EW'(node_y) + EW'(1)) < EW'(mesh_size_y);
		z_room = (EW'(node_z) + EW'(1)) < EW'(mesh_size_z);
		at_dest_xy = x_eq && y_eq;
	end

	// minimal planar odd-even set
	always_comb begin
		m_oe = '0;
		if (x_eq) begin
			if (y_lt) m_oe[PORT_N] = 1'b1;
			else m_oe[PORT_S] = 1'b1;
		end else if (x_gt) begin
			if (y_eq) begin
				m_oe[PORT_E] = 1'b1;
			end else begin
				if (cx_odd || same_x) begin
					if (y_lt) m_oe[PORT_N] = 1'b1;
					else m_oe[PORT_S] = 1'b1;
				end
				if (dx_odd || !x_next) m_oe[PORT_E] = 1'b1;
			end
		end else begin
			m_oe[PORT_W] = 1'b1;
			if (!cx_odd) begin
				if (y_lt) m_oe[PORT_N] = 1'b1;
				if (y_gt) m_oe[PORT_S] = 1'b1;
			end
		end
	end

	// north/south detours inside the mesh, no reflection
	always_comb begin
		m_ns = '0;
		m_ns[PORT_N] = (node_y != '0) && (port_in != PORT_N);
		m_ns[PORT_S] = y_room && (port_in != PORT_S);
	end

	// non-minimal planar odd-even set
	always_comb begin
		m_nm = '0;
		if (x_eq) begin
			if (y_lt) m_nm[PORT_N] = 1'b1;
			else m_nm[PORT_S] = 1'b1;
		end else if (x_gt) begin
			if (y_eq) begin
				m_nm[PORT_E] = 1'b1;
				if ((cx_odd || same_x) && !x_next) m_nm = m_nm | m_ns;
			end else if (!dx_odd && x_next) begin
				if (y_lt) m_nm[PORT_N] = 1'b1;
				else m_nm[PORT_S] = 1'b1;
			end else begin
				if (cx_odd || same_x) m_nm = m_nm | m_ns;
				if (dx_odd || !x_next) m_nm[PORT_E] = 1'b1;
			end
		end else begin
			m_nm[PORT_W] = 1'b1;
			if (!cx_odd) m_nm = m_nm | m_ns;
		end
	end

	// dimension-order fallback
	always_comb begin
		m_xyz = '0;
		if (x_gt) m_xyz[PORT_E] = 1'b1;
		else if (x_lt) m_xyz[PORT_W] = 1'b1;
		else if (y_gt) m_xyz[PORT_S] = 1'b1;
		else if (y_lt) m_xyz[PORT_N] = 1'b1;
		else if (z_lt) m_xyz[PORT_U] = 1'b1;
		else m_xyz[PORT_D] = 1'b1;
	end

	// negative-first set
	always_comb begin
		m_nf = '0;
		if (x_lt && y_lt && z_gt) begin
			m_nf[PORT_N] = 1'b1; m_nf[PORT_W] = 1'b1; m_nf[PORT_D] = 1'b1;
		end else if (x_lt && y_lt) begin
			m_nf[PORT_N] = 1'b1; m_nf[PORT_W] = 1'b1;
		end else if (x_lt && !y_lt && z_gt) begin
			m_nf[PORT_D] = 1'b1; m_nf[PORT_W] = 1'b1;
		end else if (!x_lt && y_lt && z_gt) begin
			m_nf[PORT_D] = 1'b1; m_nf[PORT_N] = 1'b1;
		end else if (x_lt && !y_lt) begin
			m_nf[PORT_W] = 1'b1;
		end else if (!x_lt && y_lt) begin
			m_nf[PORT_N] = 1'b1;
		end else if (z_gt) begin
			m_nf[PORT_D] = 1'b1;
		end else if (x_gt && y_gt && z_lt) begin
			m_nf[PORT_S] = 1'b1; m_nf[PORT_E] = 1'b1; m_nf[PORT_U] = 1'b1;
		end else if (x_gt && y_gt && z_eq) begin
			m_nf[PORT_S] = 1'b1; m_nf[PORT_E] = 1'b1;
		end else if (x_gt && y_eq && z_lt) begin
			m_nf[PORT_U] = 1'b1; m_nf[PORT_E] = 1'b1;
		end else if (x_eq && y_gt && z_lt) begin
			m_nf[PORT_U] = 1'b1; m_nf[PORT_S] = 1'b1;
		end else begin
			m_nf = m_xyz;
		end
	end

	// per-mode admissible set
	always_comb begin
		m_sel = '0;
		case (routing_mode)
			MODE_NEG_1ST: begin
				m_sel = m_nf;
			end
			MODE_OE: begin
				if (z_eq) begin
					m_sel = m_oe;
				end else if (z_gt) begin
					if (at_dest_xy) begin
						m_sel[PORT_D] = 1'b1;
					end else begin
						if (cz_odd || same_z) m_sel = m_oe;
						if (dest_z[0] || !z_next) m_sel[PORT_D] = 1'b1;
					end
				end else begin
					// up-going on an even layer with planar moves left: planar set replaces up
					if (!at_dest_xy && !cz_odd) m_sel = m_oe;
					else m_sel[PORT_U] = 1'b1;
				end
			end
			MODE_DOWN_OE: begin
				if (z_gt) begin
					m_sel[PORT_D] = 1'b1;
				end else if (z_lt && at_dest_xy) begin
					m_sel[PORT_U] = 1'b1;
				end else begin
					m_sel = m_nm;
					if (z_room) m_sel[PORT_D] = 1'b1;
				end
			end
			MODE_OE_NMIN: begin
				if (z_gt) begin
					if (!at_dest_xy) m_sel = m_nm;
					m_sel[PORT_D] = 1'b1;
				end else if (z_lt && at_dest_xy) begin
					m_sel[PORT_U] = 1'b1;
				end else begin
					m_sel = m_nm;
					if (z_room && (port_in != PORT_D)) m_sel[PORT_D] = 1'b1;
				end
			end
			default: begin
				m_sel = '0;
			end
		endcase
	end

	// balanced mode forbidden turns
	always_comb begin
		bal_ok = 1'b1;
		if (port_in != port_out) begin
			if (!cx_odd) begin
				if ((port_in == PORT_E) && ((port_out == PORT_N) || (port_out == PORT_S)))
					bal_ok = 1'b0;
			end else begin
				if (((port_in == PORT_N) || (port_in == PORT_S)) && (port_out == PORT_W))
					bal_ok = 1'b0;
			end
			if ((port_out == PORT_U) && !z_lt) bal_ok = 1'b0;
			if ((port_out == PORT_D) && !z_gt) bal_ok = 1'b0;
		end
	end

	// unused leaving port codes index the zero bits above the set
	assign m_ext = {2'b00, m_sel};

	always_comb begin
		case (routing_mode)
			MODE_NEG_1ST, MODE_OE, MODE_DOWN_OE, MODE_OE_NMIN: turn_allowed = m_ext[port_out];
			MODE_BALANCED: turn_allowed = bal_ok;
			default: turn_allowed = 1'b1;
		endcase
	end

endmodule

[rtl/mesh_turn_permission_check.sv]
// mesh_turn_permission_check: turn permission check for one 3D mesh router, top level
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  in       | in_valid / in_ready   | port_in, port_out, dest_x, dest_y, dest_z
//  out      | out_valid / out_ready | turn_allowed
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one item per cycle unless out_ready is low with both registers full; each input transfer
//  loads the input register, then the decision logic feeds the result register
//  in_ready drops only when both the input and result registers are full and out_ready is low
//  cfg_ready is always high; reset loads mode any, sizes 4, node 0
module mesh_turn_permission_check import mtpc_pkg::*; #(
	parameter int COORD_BITS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  port_code_t            port_in,
	input  port_code_t            port_out,
	input  logic [COORD_BITS-1:0] dest_x,
	input  logic [COORD_BITS-1:0] dest_y,
	input  logic [COORD_BITS-1:0] dest_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  turn_allowed,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  reg_index_t            cfg_index,
	input  logic [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)-1:0] cfg_data
);

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(4);

	mode_code_t            routing_mode_q;
	logic [SIZE_BITS-1:0]  mesh_size_y_q;
	logic [SIZE_BITS-1:0]  mesh_size_z_q;
	logic [COORD_BITS-1:0] node_x_q;
	logic [COORD_BITS-1:0] node_y_q;
	logic [COORD_BITS-1:0] node_z_q;

	logic                  valid_s1;
	port_code_t            port_in_s1;
	port_code_t            port_out_s1;
	logic [COORD_BITS-1:0] dest_x_s1;
	logic [COORD_BITS-1:0] dest_y_s1;
	logic [COORD_BITS-1:0] dest_z_s1;

	logic                  out_valid_q;
	logic                  turn_allowed_q;
	logic                  decide;
	logic                  adv_out;

	assign cfg_ready = 1'b1;

	// x size has no bearing on any mode, so a write to it is taken and dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			routing_mode_q <= MODE_ANY;
			mesh_size_y_q  <= SIZE_RESET;
			mesh_size_z_q  <= SIZE_RESET;
			node_x_q       <= '0;
			node_y_q       <= '0;
			node_z_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:   routing_mode_q <= cfg_data[2:0];
				REG_SIZE_Y: mesh_size_y_q  <= cfg_data[SIZE_BITS-1:0];
				REG_SIZE_Z: mesh_size_z_q  <= cfg_data[SIZE_BITS-1:0];
				REG_NODE_X: node_x_q       <= cfg_data[COORD_BITS-1:0];
				REG_NODE_Y: node_y_q       <= cfg_data[COORD_BITS-1:0];
				REG_NODE_Z: node_z_q       <= cfg_data[COORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv_out  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			port_in_s1  <= port_in;
			port_out_s1 <= port_out;
			dest_x_s1   <= dest_x;
			dest_y_s1   <= dest_y;
			dest_z_s1   <= dest_z;
		end
	end

	mtpc_decide #(
		.COORD_BITS(COORD_BITS)
	) u_decide (
		.routing_mode (routing_mode_q),
		.mesh_size_y  (mesh_size_y_q),
		.mesh_size_z  (mesh_size_z_q),
		.node_x       (node_x_q),
		.node_y       (node_y_q),
		.node_z       (node_z_q),
		.port_in      (port_in_s1),
		.port_out     (port_out_s1),
		.dest_x       (dest_x_s1),
		.dest_y       (dest_y_s1),
		.dest_z       (dest_z_s1),
		.turn_allowed (decide)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			turn_allowed_q <= decide;
		end
	end

	assign out_valid    = out_valid_q;
	assign turn_allowed = turn_allowed_q;

endmodule
